FILE: hw/rtl/rfs_pkg.sv
// Shared types and constants for the radial falloff sprite pixel block.
// Used by radial_falloff_sprite_pixel and its bench; no dependencies of its own.
`default_nettype none
package rfs_pkg;

    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_OFS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_FAC  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_OFS  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_FAC  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FALLOFF    = 3'd7;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [15:0] Q15_ONE = 16'h8000;

    typedef struct packed {
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [7:0]         old_byte0;
        logic [7:0]         old_byte1;
        logic [7:0]         old_byte2;
        logic [7:0]         old_byte3;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  tex_x;
        logic [7:0]  tex_y;
        logic [17:0] byte_offset;
        logic [7:0]  new_byte0;
        logic [7:0]  new_byte1;
        logic [7:0]  new_byte2;
        logic [7:0]  new_byte3;
    } out_word_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rfs_sqrt_stage.sv
// One registered stage of a restoring integer square root, STEPS bits per stage.
// Standalone; no package dependencies.
`default_nettype none
module rfs_sqrt_stage #(
    parameter int unsigned NW    = 64,
    parameter int unsigned RW    = 32,
    parameter int unsigned STEPS = 4,
    parameter int unsigned SHIFT = 60   // position of the first bit pair handled
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] rem_in,
    input  wire logic [RW-1:0] root_in,
    output logic [NW-1:0]      rem_reg,
    output logic [RW-1:0]      root_reg
);
    logic [NW-1:0] rem_next;
    logic [RW-1:0] root_next;

    // digit-by-digit: trial = (root << 2 + 1) << shift
    always_comb
    begin
        logic [NW+1:0] trial;
        rem_next  = rem_in;
        root_next = root_in;
        for (int i = 0; i < STEPS; i++)
        begin
            trial = ({{(NW+2-RW){1'b0}}, root_next} << 2 | (NW+2)'(1))
                    << (SHIFT - 2*i);
            root_next = root_next << 1;
            if ({2'b00, rem_next} >= trial)
            begin
                rem_next  = rem_next - trial[NW-1:0];
                root_next = root_next | RW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/radial_falloff_sprite_pixel.sv
// Top level of the radial falloff sprite pixel block.
// Depends on rfs_pkg and rfs_sqrt_stage.
//
// Usage:
//  in_valid/in_stall/in_data carry one pixel word per handshake; out_valid,
//  out_stall and out_data return one result word per accepted input word.
//  Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//  only while the pipe is empty. Writes to indexes above 7 are dropped.
//  Throughput: one word per clock while the pipe is not frozen (see Stall).
//  Depth: 94 register stages. Most of that is the iterative chains (distance
//  root, divide, twelve power roots) done a few result bits per stage.
//  Stall: all stages advance together; while out_stall holds with a valid
//  output word, the whole pipe freezes and in_stall is raised, so nothing is
//  lost or repeated. Bubbles are not squeezed out: the pipe freezes whenever
//  the output register is full and stalled.
//  Reset: clears all valid bits and loads register reset values.
`default_nettype none
module radial_falloff_sprite_pixel #(
    parameter int unsigned TEX_WIDTH   = 256,
    parameter int unsigned TEX_HEIGHT  = 256,
    parameter int unsigned PIXEL_BYTES = 4,
    parameter int unsigned COLOR_BYTES = 3,
    parameter int unsigned ALPHA_BYTES = 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rfs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire rfs_pkg::in_word_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output rfs_pkg::out_word_t                 out_data
);
    // ---------------- configuration ----------------
    logic signed [11:0] center_x_reg, center_y_reg;
    logic [10:0]        half_width_reg;
    logic signed [15:0] color_ofs_reg, color_fac_reg, alpha_ofs_reg, alpha_fac_reg;
    logic [15:0]        falloff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= 12'sd128;
            center_y_reg   <= 12'sd128;
            half_width_reg <= 11'd128;
            color_ofs_reg  <= '0;
            color_fac_reg  <= 16'sd4096;
            alpha_ofs_reg  <= '0;
            alpha_fac_reg  <= 16'sd4096;
            falloff_reg    <= 16'd4096;
        end
        else if (cfg_we && cfg_index[rfs_pkg::CFG_INDEX_W-1] == 1'b0)
        begin
            unique case (cfg_index[rfs_pkg::REG_IDX_W-1:0])
                rfs_pkg::REG_CENTER_X:   center_x_reg   <= cfg_data[11:0];
                rfs_pkg::REG_CENTER_Y:   center_y_reg   <= cfg_data[11:0];
                rfs_pkg::REG_HALF_WIDTH: half_width_reg <= cfg_data[10:0];
                rfs_pkg::REG_COLOR_OFS:  color_ofs_reg  <= cfg_data;
                rfs_pkg::REG_COLOR_FAC:  color_fac_reg  <= cfg_data;
                rfs_pkg::REG_ALPHA_OFS:  alpha_ofs_reg  <= cfg_data;
                rfs_pkg::REG_ALPHA_FAC:  alpha_fac_reg  <= cfg_data;
                rfs_pkg::REG_FALLOFF:    falloff_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Global enable: pipe moves unless the output word is held.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Widths
    localparam int unsigned CW  = 13;      // clamped coordinate, 0..TEX_WIDTH-1 or 0..TEX_HEIGHT-1
    localparam int unsigned D2W = 30;      // dx^2+dy^2 < 2*(6143^2) < 2^27
    localparam int unsigned N1W = D2W + 30;
    localparam int unsigned R1W = N1W / 2; // 30
    localparam int unsigned OFW = 18;

    // Payload carried alongside the whole pipe.
    typedef struct packed {
        logic [7:0]  tex_x;
        logic [7:0]  tex_y;
        logic [OFW-1:0] ofs;
        logic [31:0] old;
    } side_t;

    // ---- stage A: clamp, offset, deltas ----
    logic           a_vld_reg;
    side_t          a_side_reg;
    logic signed [13:0] a_dx_reg, a_dy_reg;

    function automatic logic [CW-1:0] clamp_c(input logic signed [11:0] v,
                                               input int unsigned lim);
        logic [CW-1:0] r;
        if (v < 0)
            r = '0;
        else if ($unsigned(13'(v)) > 13'(lim - 1))
            r = CW'(lim - 1);
        else
            r = CW'($unsigned(v));
        return r;
    endfunction

    logic [CW-1:0] tx_c, ty_c;
    assign tx_c = clamp_c(in_data.pos_x, TEX_WIDTH);
    assign ty_c = clamp_c(in_data.pos_y, TEX_HEIGHT);

    logic [63:0] ofs_full;
    assign ofs_full = 64'(ty_c) * 64'(TEX_WIDTH) * 64'(PIXEL_BYTES)
                    + 64'(tx_c) * 64'(PIXEL_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg.tex_x <= tx_c[7:0];
            a_side_reg.tex_y <= ty_c[7:0];
            a_side_reg.ofs   <= ofs_full[OFW-1:0];
            a_side_reg.old   <= {in_data.old_byte3, in_data.old_byte2,
                                 in_data.old_byte1, in_data.old_byte0};
            a_dx_reg <= $signed({1'b0, tx_c}) - 14'(center_x_reg);
            a_dy_reg <= $signed({1'b0, ty_c}) - 14'(center_y_reg);
        end
    end

    // ---- stage B: squares ----
    logic        b_vld_reg;
    side_t       b_side_reg;
    logic [D2W-1:0] b_sx_reg, b_sy_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (adv)
            b_vld_reg <= a_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_side_reg <= a_side_reg;
            b_sx_reg   <= D2W'($unsigned(28'(a_dx_reg) * 28'(a_dx_reg)));
            b_sy_reg   <= D2W'($unsigned(28'(a_dy_reg) * 28'(a_dy_reg)));
        end
    end

    // ---- stage C: sum, shift into root operand ----
    logic        c_vld_reg;
    side_t       c_side_reg;
    logic [N1W-1:0] c_n_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (adv)
            c_vld_reg <= b_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_side_reg <= b_side_reg;
            c_n_reg    <= {b_sx_reg + b_sy_reg, 30'd0};
        end
    end

    // ---- distance root: 30 result bits, 3 per stage ----
    localparam int unsigned S1 = 3;
    localparam int unsigned NS1 = R1W / S1;   // 10
    logic [N1W-1:0] r1_rem [NS1+1];
    logic [R1W-1:0] r1_root[NS1+1];
    logic           r1_vld [NS1+1];
    side_t          r1_side[NS1+1];
    assign r1_rem[0]  = c_n_reg;
    assign r1_root[0] = '0;
    assign r1_vld[0]  = c_vld_reg;
    assign r1_side[0] = c_side_reg;

    for (genvar g = 0; g < NS1; g++)
    begin : g_root1
        rfs_sqrt_stage #(.NW(N1W), .RW(R1W), .STEPS(S1),
                         .SHIFT(N1W - 2 - 2*S1*g)) u_stage (
            .clk(clk), .en(adv),
            .rem_in(r1_rem[g]), .root_in(r1_root[g]),
            .rem_reg(r1_rem[g+1]), .root_reg(r1_root[g+1]));
        logic  vld_reg;
        side_t side_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (adv)
                vld_reg <= r1_vld[g];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg <= r1_side[g];
        end
        assign r1_vld[g+1]  = vld_reg;
        assign r1_side[g+1] = side_reg;
    end

    // ---- divide root by half_width: restoring, 3 quotient bits per stage ----
    // Quotient needs 16 bits (saturated at 32768); bits above that only flag overflow.
    localparam int unsigned QW  = R1W;         // full quotient width
    localparam int unsigned DS  = 3;
    localparam int unsigned NDS = QW / DS;     // 10
    logic [QW-1:0] dv_num [NDS+1];  // remaining dividend bits (shifted out top)
    logic [10:0]   dv_rem [NDS+1];
    logic [QW-1:0] dv_q   [NDS+1];
    logic          dv_vld [NDS+1];
    side_t         dv_side[NDS+1];
    assign dv_num[0]  = r1_root[NS1];
    assign dv_rem[0]  = '0;
    assign dv_q[0]    = '0;
    assign dv_vld[0]  = r1_vld[NS1];
    assign dv_side[0] = r1_side[NS1];

    for (genvar g = 0; g < NDS; g++)
    begin : g_div
        logic [QW-1:0] num_next, q_next;
        logic [10:0]   rem_next;
        always_comb
        begin
            logic [11:0] t;
            num_next = dv_num[g];
            rem_next = dv_rem[g];
            q_next   = dv_q[g];
            for (int i = 0; i < DS; i++)
            begin
                t = {rem_next, num_next[QW-1]};
                num_next = num_next << 1;
                q_next   = q_next << 1;
                if (t >= {1'b0, half_width_reg})
                begin
                    t = t - {1'b0, half_width_reg};
                    q_next = q_next | QW'(1);
                end
                rem_next = t[10:0];
            end
        end
        logic [QW-1:0] num_reg, q_reg;
        logic [10:0]   rem_reg;
        logic          vld_reg;
        side_t         side_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (adv)
                vld_reg <= dv_vld[g];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg  <= num_next;
                rem_reg  <= rem_next;
                q_reg    <= q_next;
                side_reg <= dv_side[g];
            end
        end
        assign dv_num[g+1]  = num_reg;
        assign dv_rem[g+1]  = rem_reg;
        assign dv_q[g+1]    = q_reg;
        assign dv_vld[g+1]  = vld_reg;
        assign dv_side[g+1] = side_reg;
    end

    // ---- saturate distance ----
    logic        e_vld_reg;
    side_t       e_side_reg;
    logic [15:0] e_d_reg;   // Q1.15; 16'h8000 = 1.0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (adv)
            e_vld_reg <= dv_vld[NDS];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_side_reg <= dv_side[NDS];
            if (half_width_reg == '0 || dv_q[NDS] > QW'(32768))
                e_d_reg <= rfs_pkg::Q15_ONE;
            else
                e_d_reg <= dv_q[NDS][15:0];
        end
    end

    // ---- power ladder ----
    // Squares for k=13..15 (one register each), then 12 roots downward,
    // then 16 multiply steps. Every s_k travels along so multiplies can use it.
    typedef logic [16:0] sval_t;   // values up to 32768
    typedef sval_t sarr_t [16];

    // squaring stages
    sval_t sq_s   [4][16];
    logic  sq_vld [4];
    side_t sq_side[4];
    for (genvar k = 0; k < 16; k++)
    begin : g_sq0
        assign sq_s[0][k] = (k == 12) ? {1'b0, e_d_reg} : '0;
    end
    assign sq_vld[0]  = e_vld_reg;
    assign sq_side[0] = e_side_reg;

    for (genvar g = 0; g < 3; g++)
    begin : g_sq
        sval_t s_reg [16];
        logic  vld_reg;
        side_t side_reg;
        logic [33:0] prod;
        assign prod = 34'(sq_s[g][12+g]) * 34'(sq_s[g][12+g]);
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (adv)
                vld_reg <= sq_vld[g];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int k = 0; k < 16; k++)
                    s_reg[k] <= (k == 13 + g) ? prod[31:15] : sq_s[g][k];
                side_reg <= sq_side[g];
            end
        end
        for (genvar k = 0; k < 16; k++)
        begin : g_o
            assign sq_s[g+1][k] = s_reg[k];
        end
        assign sq_vld[g+1]  = vld_reg;
        assign sq_side[g+1] = side_reg;
    end

    // root chain: s_k = isqrt(s_{k+1} << 15); operand < 2^31, root 16 bits,
    // 4 bits per stage -> 4 stages per root, 12 roots.
    localparam int unsigned PNW = 32;
    localparam int unsigned PRW = 16;
    localparam int unsigned PS  = 4;
    localparam int unsigned PNS = PRW / PS;
    localparam int unsigned NR  = 12;
    localparam int unsigned RT  = NR * PNS;

    logic [PNW-1:0] pr_rem [RT+1];
    logic [PRW-1:0] pr_root[RT+1];
    sval_t          pr_s   [RT+1][16];
    logic           pr_vld [RT+1];
    side_t          pr_side[RT+1];

    assign pr_rem[0]  = {sq_s[3][12][16:0], 15'd0};
    assign pr_root[0] = '0;
    for (genvar k = 0; k < 16; k++)
    begin : g_pr0
        assign pr_s[0][k] = sq_s[3][k];
    end
    assign pr_vld[0]  = sq_vld[3];
    assign pr_side[0] = sq_side[3];

    for (genvar r = 0; r < NR; r++)
    begin : g_rt
        for (genvar st = 0; st < PNS; st++)
        begin : g_st
            localparam int unsigned IDX = r * PNS + st;
            logic [PNW-1:0] rem_in;
            logic [PRW-1:0] root_in;
            // first stage of a root starts from the root just finished
            if (st == 0 && r > 0)
            begin : g_ld
                assign rem_in  = {1'b0, pr_root[IDX], 15'd0};
                assign root_in = '0;
            end
            else
            begin : g_pass
                assign rem_in  = pr_rem[IDX];
                assign root_in = pr_root[IDX];
            end
            rfs_sqrt_stage #(.NW(PNW), .RW(PRW), .STEPS(PS),
                             .SHIFT(PNW - 2 - 2*PS*st)) u_stage (
                .clk(clk), .en(adv),
                .rem_in(rem_in), .root_in(root_in),
                .rem_reg(pr_rem[IDX+1]), .root_reg(pr_root[IDX+1]));
            sval_t s_reg [16];
            logic  vld_reg;
            side_t side_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg <= 1'b0;
                else if (adv)
                    vld_reg <= pr_vld[IDX];
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    // previous root completed in pr_root at this stage's input
                    for (int k = 0; k < 16; k++)
                        s_reg[k] <= (st == 0 && r > 0 && k == 12 - r) ?
                                    {1'b0, pr_root[IDX]} : pr_s[IDX][k];
                    side_reg <= pr_side[IDX];
                end
            end
            for (genvar k = 0; k < 16; k++)
            begin : g_o
                assign pr_s[IDX+1][k] = s_reg[k];
            end
            assign pr_vld[IDX+1]  = vld_reg;
            assign pr_side[IDX+1] = side_reg;
        end
    end

    // final root lands in s_0
    sval_t          ml_s   [17][16];
    logic [16:0]    ml_p   [17];
    logic           ml_vld [17];
    side_t          ml_side[17];
    for (genvar k = 0; k < 16; k++)
    begin : g_ml0
        assign ml_s[0][k] = (k == 0) ? {1'b0, pr_root[RT]} : pr_s[RT][k];
    end
    assign ml_p[0]    = 17'd32768;
    assign ml_vld[0]  = pr_vld[RT];
    assign ml_side[0] = pr_side[RT];

    // multiply chain, one exponent bit per stage
    for (genvar k = 0; k < 16; k++)
    begin : g_mul
        logic [33:0] prod;
        assign prod = 34'(ml_p[k]) * 34'(ml_s[k][k]);
        logic [16:0] p_reg;
        sval_t       s_reg [16];
        logic        vld_reg;
        side_t       side_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (adv)
                vld_reg <= ml_vld[k];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p_reg    <= falloff_reg[k] ? prod[31:15] : ml_p[k];
                for (int j = 0; j < 16; j++)
                    s_reg[j] <= ml_s[k][j];
                side_reg <= ml_side[k];
            end
        end
        for (genvar j = 0; j < 16; j++)
        begin : g_o
            assign ml_s[k+1][j] = s_reg[j];
        end
        assign ml_p[k+1]    = p_reg;
        assign ml_vld[k+1]  = vld_reg;
        assign ml_side[k+1] = side_reg;
    end

    // ---- terms: t = factor*f + offset*32768 ----
    logic        t_vld_reg;
    side_t       t_side_reg;
    logic signed [34:0] t_c_reg, t_a_reg;
    logic signed [17:0] f_s;
    assign f_s = $signed({1'b0, 17'(17'd32768 - ml_p[16])});
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_vld_reg <= 1'b0;
        else if (adv)
            t_vld_reg <= ml_vld[16];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_side_reg <= ml_side[16];
            t_c_reg <= 35'(color_fac_reg * f_s)
                     + 35'($signed({color_ofs_reg, 15'd0}));
            t_a_reg <= 35'(alpha_fac_reg * f_s)
                     + 35'($signed({alpha_ofs_reg, 15'd0}));
        end
    end

    // ---- times 255 ----
    logic        u_vld_reg;
    side_t       u_side_reg;
    logic signed [43:0] u_c_reg, u_a_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            u_vld_reg <= 1'b0;
        else if (adv)
            u_vld_reg <= t_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_side_reg <= t_side_reg;
            u_c_reg <= (44'(t_c_reg) <<< 8) - 44'(t_c_reg);
            u_a_reg <= (44'(t_a_reg) <<< 8) - 44'(t_a_reg);
        end
    end

    function automatic logic [7:0] apply_byte(input logic [7:0] old,
                                              input logic signed [43:0] u);
        logic signed [44:0] v;
        logic [7:0] r;
        v = $signed({2'b00, old, 27'd0}) + 45'(u);
        if (v < 0)
            r = '0;
        else if (v[44:27] > 18'd255)
            r = 8'hFF;
        else
            r = v[34:27];
        return r;
    endfunction

    // ---- output register ----
    logic      out_vld_reg;
    rfs_pkg::out_word_t out_reg;
    logic [7:0] nb [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            nb[i] = u_side_reg.old[8*i +: 8];
            if (i < PIXEL_BYTES)
            begin
                if (i < COLOR_BYTES)
                    nb[i] = apply_byte(u_side_reg.old[8*i +: 8], u_c_reg);
                else if (i < COLOR_BYTES + ALPHA_BYTES)
                    nb[i] = apply_byte(u_side_reg.old[8*i +: 8], u_a_reg);
            end
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= u_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.tex_x       <= u_side_reg.tex_x;
            out_reg.tex_y       <= u_side_reg.tex_y;
            out_reg.byte_offset <= u_side_reg.ofs;
            out_reg.new_byte0   <= nb[0];
            out_reg.new_byte1   <= nb[1];
            out_reg.new_byte2   <= nb[2];
            out_reg.new_byte3   <= nb[3];
        end
    end
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

FILE: test/radial_falloff_sprite_pixel_test.sv
// Self-checking bench for radial_falloff_sprite_pixel: drives pixel words with random
// idling, predicts each result in fixed point and compares word by word.
// Depends on rfs_pkg and the block's RTL.
`default_nettype none
module radial_falloff_sprite_pixel_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TEXW = 256;
    localparam int unsigned TEXH = 256;
    localparam int unsigned PIXB = 4;
    localparam int unsigned COLB = 3;
    localparam int unsigned ALPB = 1;
    localparam int unsigned PIPE_DRAIN = 400;
    localparam int unsigned N_RANDOM = 1000;
    localparam int unsigned IW = rfs_pkg::CFG_INDEX_W;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [rfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    rfs_pkg::in_word_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rfs_pkg::out_word_t out_data;

    // register shadow
    logic signed [11:0] sh_cx, sh_cy;
    logic [10:0] sh_hw;
    logic signed [15:0] sh_cofs, sh_cfac, sh_aofs, sh_afac;
    logic [15:0] sh_fexp;

    rfs_pkg::out_word_t pixel_q[$];
    int mismatches = 0;
    int sender_idle = 37;
    int receiver_idle = 50;

    radial_falloff_sprite_pixel #(
        .TEX_WIDTH(TEXW), .TEX_HEIGHT(TEXH), .PIXEL_BYTES(PIXB),
        .COLOR_BYTES(COLB), .ALPHA_BYTES(ALPB)
    ) u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned falloff_pow(longint unsigned d, logic [15:0] e);
        longint unsigned s[16];
        longint unsigned p;
        p = 32768;
        s[12] = d;
        for (int k = 13; k < 16; k++)
            s[k] = (s[k-1] * s[k-1]) >> 15;
        for (int k = 11; k >= 0; k--)
            s[k] = int_root(s[k+1] << 15);
        for (int k = 0; k < 16; k++)
            if (e[k])
                p = (p * s[k]) >> 15;
        return p;
    endfunction

    function automatic logic [7:0] blend_byte(logic [7:0] old, longint t);
        longint v;
        v = longint'(old) * (longint'(1) << 27) + t * 255;
        if (v < 0)
            return 8'd0;
        v = v >>> 27;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic rfs_pkg::out_word_t predict_pixel(rfs_pkg::in_word_t w);
        rfs_pkg::out_word_t r;
        longint tx, ty, dx, dy, ct, at;
        longint unsigned d2, d, f;
        logic [7:0] olds[4];
        logic [7:0] nb[4];
        tx = longint'(w.pos_x);
        ty = longint'(w.pos_y);
        tx = (tx < 0) ? 0 : ((tx > TEXW - 1) ? TEXW - 1 : tx);
        ty = (ty < 0) ? 0 : ((ty > TEXH - 1) ? TEXH - 1 : ty);
        dx = tx - longint'(sh_cx);
        dy = ty - longint'(sh_cy);
        d2 = dx * dx + dy * dy;
        if (sh_hw == 0)
            d = 32768;
        else
        begin
            d = int_root(d2 << 30) / sh_hw;
            if (d > 32768)
                d = 32768;
        end
        f = 32768 - falloff_pow(d, sh_fexp);
        ct = longint'(sh_cfac) * longint'(f) + longint'(sh_cofs) * 32768;
        at = longint'(sh_afac) * longint'(f) + longint'(sh_aofs) * 32768;
        olds = '{w.old_byte0, w.old_byte1, w.old_byte2, w.old_byte3};
        for (int i = 0; i < 4; i++)
        begin
            nb[i] = olds[i];
            if (i < PIXB)
            begin
                if (i < COLB)
                    nb[i] = blend_byte(olds[i], ct);
                else if (i < COLB + ALPB)
                    nb[i] = blend_byte(olds[i], at);
            end
        end
        r.tex_x = tx[7:0];
        r.tex_y = ty[7:0];
        r.byte_offset = 18'(ty * TEXW * PIXB + tx * PIXB);
        r.new_byte0 = nb[0];
        r.new_byte1 = nb[1];
        r.new_byte2 = nb[2];
        r.new_byte3 = nb[3];
        return r;
    endfunction

    // one write, then cfg_we is dropped before returning so back-to-back writes never collide
    task automatic write_reg(logic [IW-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        unique case (idx)
            IW'(rfs_pkg::REG_CENTER_X):   sh_cx = val[11:0];
            IW'(rfs_pkg::REG_CENTER_Y):   sh_cy = val[11:0];
            IW'(rfs_pkg::REG_HALF_WIDTH): sh_hw = val[10:0];
            IW'(rfs_pkg::REG_COLOR_OFS):  sh_cofs = val;
            IW'(rfs_pkg::REG_COLOR_FAC):  sh_cfac = val;
            IW'(rfs_pkg::REG_ALPHA_OFS):  sh_aofs = val;
            IW'(rfs_pkg::REG_ALPHA_FAC):  sh_afac = val;
            IW'(rfs_pkg::REG_FALLOFF):    sh_fexp = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    // one word; expectation is either given or predicted.
    // in_valid stays high on return so the next word can follow with no gap.
    task automatic send_pixel(rfs_pkg::in_word_t w, bit given, rfs_pkg::out_word_t exp_w);
        while ($urandom_range(99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        pixel_q.push_back(given ? exp_w : predict_pixel(w));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic rfs_pkg::in_word_t rand_pixel();
        rfs_pkg::in_word_t w;
        w = rfs_pkg::in_word_t'(56'({$urandom, $urandom}));
        // mostly land inside the texture
        if ($urandom_range(3) != 0)
        begin
            w.pos_x = 12'($urandom_range(255));
            w.pos_y = 12'($urandom_range(255));
        end
        return w;
    endfunction

    task automatic random_config();
        write_reg(IW'(rfs_pkg::REG_CENTER_X),
            16'($urandom_range(3) == 0 ? $urandom : $urandom_range(255)));
        write_reg(IW'(rfs_pkg::REG_CENTER_Y),
            16'($urandom_range(3) == 0 ? $urandom : $urandom_range(255)));
        write_reg(IW'(rfs_pkg::REG_HALF_WIDTH),
            16'($urandom_range(7) == 0 ? 0 : $urandom_range(2047)));
        write_reg(IW'(rfs_pkg::REG_COLOR_OFS),
            16'($urandom_range(1) ? $urandom : $urandom_range(8191) - 4096));
        write_reg(IW'(rfs_pkg::REG_COLOR_FAC), 16'($urandom));
        write_reg(IW'(rfs_pkg::REG_ALPHA_OFS),
            16'($urandom_range(1) ? $urandom : $urandom_range(8191) - 4096));
        write_reg(IW'(rfs_pkg::REG_ALPHA_FAC), 16'($urandom));
        write_reg(IW'(rfs_pkg::REG_FALLOFF), 16'($urandom));
    endtask

    // receive side
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < receiver_idle);

    always @(posedge clk)
    begin
        rfs_pkg::out_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", out_data);
            end
            else
            begin
                exp_w = pixel_q.pop_front();
                if (out_data !== exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp x=%0d y=%0d ofs=%0d b=%h %h %h %h,",
                                  " got x=%0d y=%0d ofs=%0d b=%h %h %h %h"},
                            exp_w.tex_x, exp_w.tex_y, exp_w.byte_offset, exp_w.new_byte0,
                            exp_w.new_byte1, exp_w.new_byte2, exp_w.new_byte3,
                            out_data.tex_x, out_data.tex_y, out_data.byte_offset,
                            out_data.new_byte0, out_data.new_byte1, out_data.new_byte2,
                            out_data.new_byte3);
                end
            end
        end
    end

    typedef struct {
        rfs_pkg::in_word_t w;
        bit given;
        rfs_pkg::out_word_t exp_w;
    } pixel_row_t;

    initial
    begin
        pixel_row_t rows[$];
        rfs_pkg::out_word_t zero_w;
        int phase;
        zero_w = '0;
        sh_cx = 12'sd128;
        sh_cy = 12'sd128;
        sh_hw = 11'd128;
        sh_cofs = 16'sd0;
        sh_cfac = 16'sd4096;
        sh_aofs = 16'sd0;
        sh_afac = 16'sd4096;
        sh_fexp = 16'd4096;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: at the center f = 1, so every byte goes to 255
        rows.push_back('{'{12'sd128, 12'sd128, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
            '{8'd128, 8'd128, 18'(128 * 1024 + 512), 8'd255, 8'd255, 8'd255, 8'd255}});
        // far corner, clamped negative: distance clamps to 1, bytes pass
        rows.push_back('{'{12'sh800, 12'sh800, 8'd17, 8'd0, 8'd255, 8'd3}, 1'b1,
            '{8'd0, 8'd0, 18'd0, 8'd17, 8'd0, 8'd255, 8'd3}});
        rows.push_back('{'{12'sd2047, 12'sd2047, 8'd255, 8'd1, 8'd2, 8'd4}, 1'b0, zero_w});
        rows.push_back('{'{12'sd255, 12'sd0, 8'd128, 8'd64, 8'd32, 8'd200}, 1'b0, zero_w});
        rows.push_back('{'{12'sd0, 12'sd255, 8'd90, 8'd91, 8'd92, 8'd93}, 1'b0, zero_w});
        rows.push_back('{'{12'sd100, 12'sd140, 8'd0, 8'd255, 8'd0, 8'd255}, 1'b0, zero_w});
        rows.push_back('{'{-12'sd1, 12'sd256, 8'd170, 8'd85, 8'd170, 8'd85}, 1'b0, zero_w});
        foreach (rows[i])
            send_pixel(rows[i].w, rows[i].given, rows[i].exp_w);
        wait_drained();

        // zero half width, then zero exponent: f = 0 everywhere
        write_reg(IW'(rfs_pkg::REG_HALF_WIDTH), 16'd0);
        write_reg(IW'(8), 16'hFFFF);   // out of range index, dropped
        write_reg(IW'(15), 16'h0000);
        send_pixel('{12'sd128, 12'sd128, 8'd10, 8'd20, 8'd30, 8'd40}, 1'b1,
            '{8'd128, 8'd128, 18'(128 * 1024 + 512), 8'd10, 8'd20, 8'd30, 8'd40});
        wait_drained();
        write_reg(IW'(rfs_pkg::REG_HALF_WIDTH), 16'd2047);
        write_reg(IW'(rfs_pkg::REG_FALLOFF), 16'd0);
        send_pixel('{12'sd128, 12'sd128, 8'd10, 8'd20, 8'd30, 8'd40}, 1'b1,
            '{8'd128, 8'd128, 18'(128 * 1024 + 512), 8'd10, 8'd20, 8'd30, 8'd40});
        wait_drained();

        // extremes of every register
        write_reg(IW'(rfs_pkg::REG_CENTER_X), 16'h0800);
        write_reg(IW'(rfs_pkg::REG_CENTER_Y), 16'h07FF);
        write_reg(IW'(rfs_pkg::REG_HALF_WIDTH), 16'd1);
        write_reg(IW'(rfs_pkg::REG_COLOR_OFS), 16'h7FFF);
        write_reg(IW'(rfs_pkg::REG_COLOR_FAC), 16'h8000);
        write_reg(IW'(rfs_pkg::REG_ALPHA_OFS), 16'h8000);
        write_reg(IW'(rfs_pkg::REG_ALPHA_FAC), 16'h7FFF);
        write_reg(IW'(rfs_pkg::REG_FALLOFF), 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_pixel(rand_pixel(), 1'b0, zero_w);
        wait_drained();
        write_reg(IW'(rfs_pkg::REG_CENTER_X), 16'd0);
        write_reg(IW'(rfs_pkg::REG_CENTER_Y), 16'd255);
        write_reg(IW'(rfs_pkg::REG_HALF_WIDTH), 16'd2047);
        write_reg(IW'(rfs_pkg::REG_COLOR_OFS), 16'hF000);
        write_reg(IW'(rfs_pkg::REG_COLOR_FAC), 16'h7FFF);
        write_reg(IW'(rfs_pkg::REG_FALLOFF), 16'h0001);
        for (int i = 0; i < 6; i++)
            send_pixel(rand_pixel(), 1'b0, zero_w);
        wait_drained();

        for (phase = 0; phase < 3; phase++)
        begin
            sender_idle = (phase == 0) ? 37 : ((phase == 1) ? 50 : 0);
            receiver_idle = (phase == 0) ? 50 : ((phase == 1) ? 37 : 0);
            for (int n = 0; n < N_RANDOM / 3; n++)
            begin
                if (n % 55 == 0)
                begin
                    wait_drained();
                    random_config();
                end
                send_pixel(rand_pixel(), 1'b0, zero_w);
            end
        end
        wait_drained();
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("radial_falloff_sprite_pixel_test: clean");
        else
            $display("radial_falloff_sprite_pixel_test: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("radial_falloff_sprite_pixel_test: errors");
        $finish;
    end
endmodule
`default_nettype wire
